### design/pits_pkg.sv
// Package: types and constants for the point-in-triangle search block.
package pits_pkg;

  localparam int unsigned IdxW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned CoordW = 16;
  localparam int unsigned Depth  = 1024;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;

  localparam logic [1:0] ReqVertex   = 2'd0;
  localparam logic [1:0] ReqTriangle = 2'd1;
  localparam logic [1:0] ReqQuery    = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IdxW-1:0]          entry_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic [IdxW-1:0]          corner_a;
    logic [IdxW-1:0]          corner_b;
    logic [IdxW-1:0]          corner_c;
  } req_t;

  typedef struct packed {
    logic [CntW-1:0] triangle_number;
    logic            found;
  } res_t;

  typedef enum logic [3:0] {
    StIdle, StTri, StVa, StVb, StVc, StE0, StE1, StE2, StCheck
  } state_e;

endpackage

### design/pits_edge.sv
// Edge test: sign of point cross product against sign of corner cross product.
module pits_edge (
  input  logic                               clk_i,
  input  logic signed [pits_pkg::CoordW-1:0] px_i,
  input  logic signed [pits_pkg::CoordW-1:0] py_i,
  input  logic signed [pits_pkg::CoordW-1:0] qx_i,
  input  logic signed [pits_pkg::CoordW-1:0] qy_i,
  input  logic signed [pits_pkg::CoordW-1:0] rx_i,
  input  logic signed [pits_pkg::CoordW-1:0] ry_i,
  input  logic signed [pits_pkg::CoordW-1:0] sx_i,
  input  logic signed [pits_pkg::CoordW-1:0] sy_i,
  output logic                               reject_o
);
  import pits_pkg::*;

  logic signed [DiffW-1:0] ex, ey, dx, dy, fx, fy;
  logic signed [ProdW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [ProdW:0]   t, u;
  logic                    tp, tn, up, un;

  assign ex = DiffW'(qx_i) - DiffW'(px_i);
  assign ey = DiffW'(qy_i) - DiffW'(py_i);
  assign dx = DiffW'(rx_i) - DiffW'(px_i);
  assign dy = DiffW'(ry_i) - DiffW'(py_i);
  assign fx = DiffW'(sx_i) - DiffW'(px_i);
  assign fy = DiffW'(sy_i) - DiffW'(py_i);

  always_ff @(posedge clk_i) begin
    m0_q <= ex * dy;
    m1_q <= ey * dx;
    m2_q <= ex * fy;
    m3_q <= ey * fx;
  end

  assign t  = (ProdW+1)'(m0_q) - (ProdW+1)'(m1_q);
  assign u  = (ProdW+1)'(m2_q) - (ProdW+1)'(m3_q);
  assign tn = t[ProdW];
  assign tp = !tn && (t != '0);
  assign un = u[ProdW];
  assign up = !un && (u != '0);
  assign reject_o = (tp && un) || (tn && up);
endmodule

### design/point_in_triangle_search.sv
// Top level: vertex and triangle memories with a sequential triangle search.
//
//  channel  | handshake          | payload
//  request  | start_i / busy_o   | req_i   (pits_pkg::req_t)
//  result   | strobe_o           | res_o   (pits_pkg::res_t)
//  config   | cfg_valid_i/ready_o| cfg_data_i (triangle_count)
//
// Loads write their memory on acceptance and leave the block free. A query tests each
// triangle in turn (triangle read, reads of corners a, b and c, edge tests c->a, a->b
// and b->c through a product register, and the check state), stopping at the first hit;
// a miss ends once all triangles are tested. The strobe is registered from the final state
// of a query, hit or miss; busy_o stays high through the strobe cycle.
// All lookups share one read port per memory. Reset clears control only; memories
// are undefined until written. The receiver cannot stall.
module point_in_triangle_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  pits_pkg::req_t            req_i,
  output logic                      strobe_o,
  output pits_pkg::res_t            res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pits_pkg::CntW-1:0] cfg_data_i
);
  import pits_pkg::*;

  logic [2*CoordW-1:0] vtx_mem [Depth];
  logic [3*IdxW-1:0]   tri_mem [Depth];
  logic [2*CoordW-1:0] vtx_rd_q;
  logic [3*IdxW-1:0]   tri_rd_q;

  state_e state_q, state_d;
  req_t   req_q;
  logic [CntW-1:0] cnt_q, lim;
  logic [CntW-1:0] t_q, t_d;
  logic [IdxW-1:0] vaddr;
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [CoordW-1:0] px, py, qx, qy, rx, ry;
  logic rej, rej_q, rej_d;
  logic [1:0] esel;
  logic done;
  logic accept;

  assign accept = start_i && !busy_o;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_valid_i) begin
      cnt_q <= cfg_data_i;
    end
  end
  assign lim = (cnt_q > CntW'(Depth)) ? CntW'(Depth) : cnt_q;

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == ReqVertex) begin
      vtx_mem[req_i.entry_index] <= {req_i.coord_x, req_i.coord_y};
    end
    if (accept && req_i.req_type == ReqTriangle) begin
      tri_mem[req_i.entry_index] <= {req_i.corner_a, req_i.corner_b, req_i.corner_c};
    end
    tri_rd_q <= tri_mem[t_q[IdxW-1:0]];
    vtx_rd_q <= vtx_mem[vaddr];
  end

  always_comb begin
    case (state_q)
      StVa:    vaddr = tri_rd_q[3*IdxW-1:2*IdxW];
      StVb:    vaddr = tri_rd_q[2*IdxW-1:IdxW];
      default: vaddr = tri_rd_q[IdxW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) req_q <= req_i;
    if (state_q == StVb) {ax_q, ay_q} <= vtx_rd_q;
    if (state_q == StVc) {bx_q, by_q} <= vtx_rd_q;
    if (state_q == StE0) {cx_q, cy_q} <= vtx_rd_q;
  end

  always_comb begin
    esel = 2'd0;
    case (state_q)
      StE2:    esel = 2'd1;
      StCheck: esel = 2'd2;
      default: esel = 2'd0;
    endcase
    case (esel)
      2'd1: begin
        px = ax_q; py = ay_q; qx = bx_q; qy = by_q; rx = cx_q; ry = cy_q;
      end
      2'd2: begin
        px = bx_q; py = by_q; qx = cx_q; qy = cy_q; rx = ax_q; ry = ay_q;
      end
      default: begin
        px = cx_q; py = cy_q; qx = ax_q; qy = ay_q; rx = bx_q; ry = by_q;
      end
    endcase
  end

  // edge c->a launched in StE1, a->b in StE2, b->c in StCheck
  pits_edge u_edge (
    .clk_i, .px_i(px), .py_i(py), .qx_i(qx), .qy_i(qy),
    .rx_i(req_q.coord_x), .ry_i(req_q.coord_y), .sx_i(rx), .sy_i(ry),
    .reject_o(rej)
  );

  logic ph_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      t_q     <= '0;
      rej_q   <= 1'b0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      rej_q   <= rej_d;
      ph_q    <= (state_q == StCheck) ? ~ph_q : 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    rej_d   = rej_q;
    done    = 1'b0;
    case (state_q)
      StIdle: begin
        t_d = '0;
        if (accept && req_i.req_type == ReqQuery) state_d = StTri;
      end
      StTri: begin
        if (t_q >= lim) begin
          done = 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StVa;
        end
      end
      StVa: state_d = StVb;
      StVb: state_d = StVc;
      StVc: state_d = StE0;
      StE0: state_d = StE1;
      StE1: state_d = StE2;
      StE2: begin
        state_d = StCheck;
        rej_d = rej;
      end
      StCheck: begin
        rej_d = rej_q | rej;
        if (ph_q) begin
          if (!(rej_q | rej)) begin
            done = 1'b1;
            state_d = StIdle;
          end else begin
            t_d = t_q + 1'b1;
            state_d = StTri;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // In StCheck, a->b is seen in the phase with ph_q low, b->c in the phase with ph_q high
  logic strobe_q;
  res_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= done;
    end
  end
  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q.found           <= (state_q == StCheck);
      res_q.triangle_number <= (state_q == StCheck) ? t_q + 1'b1 : '0;
    end
  end

  assign busy_o   = (state_q != StIdle) || strobe_q;
  assign strobe_o = strobe_q;
  assign res_o    = res_q;
endmodule
